FILE: hdl/c6502_pkg.sv
// ============================================================================
// c6502_pkg
// Shared types and constants for the 6502-style execute unit.
// ============================================================================
package c6502_pkg;

   // operation selector, dense numbering of official and unofficial operations
   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
      OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
      OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
      OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
      OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
      OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
      OP_INX = 6'd24, OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27,
      OP_LDY = 6'd28, OP_LSR = 6'd29, OP_NOP = 6'd30, OP_ORA = 6'd31,
      OP_ROL = 6'd32, OP_ROR = 6'd33, OP_SBC = 6'd34, OP_SEC = 6'd35,
      OP_SED = 6'd36, OP_SEI = 6'd37, OP_STA = 6'd38, OP_STX = 6'd39,
      OP_STY = 6'd40, OP_TAX = 6'd41, OP_TAY = 6'd42, OP_TSX = 6'd43,
      OP_TXA = 6'd44, OP_TXS = 6'd45, OP_TYA = 6'd46, OP_ANC = 6'd47,
      OP_SAX = 6'd48, OP_ARR = 6'd49, OP_ALR = 6'd50, OP_AXA = 6'd51,
      OP_AXS = 6'd52, OP_DCP = 6'd53, OP_ISC = 6'd54, OP_LAR = 6'd55,
      OP_LAX = 6'd56, OP_RLA = 6'd57, OP_RRA = 6'd58, OP_SLO = 6'd59,
      OP_SRE = 6'd60, OP_SXA = 6'd61, OP_SYA = 6'd62, OP_XAA = 6'd63
   } op_type;

   // architectural register file
   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
   } arch_regs_type;

   // status bit positions
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_U = 5;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   // reset values
   localparam logic [7:0] A_RESET  = 8'h00;
   localparam logic [7:0] X_RESET  = 8'h00;
   localparam logic [7:0] Y_RESET  = 8'h00;
   localparam logic [7:0] SP_RESET = 8'hFD;
   localparam logic [7:0] P_RESET  = 8'h24;

endpackage

FILE: hdl/c6502_alu.sv
// ============================================================================
// c6502_alu
// Single-pass operation logic: next register file, write-back byte, branch.
// ============================================================================
module c6502_alu (
   input  c6502_pkg::op_type        mode,
   input  logic [7:0]               operand,
   input  logic [15:0]              eff_address,
   input  logic                     acc_target,
   input  c6502_pkg::arch_regs_type regs_cur,
   output c6502_pkg::arch_regs_type regs_next,
   output logic [7:0]               write_data,
   output logic                     branch_taken
);

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r = p;
      r[c6502_pkg::FLAG_N] = v[7];
      r[c6502_pkg::FLAG_Z] = (v == 8'h00);
      return r;
   endfunction

   logic [7:0] a, x, y, sp, p;
   logic [7:0] wd, src, t, v;
   logic       br;
   logic [8:0] sum9;
   logic       borrow;

   always_comb begin
      a      = regs_cur.a;
      x      = regs_cur.x;
      y      = regs_cur.y;
      sp     = regs_cur.sp;
      p      = regs_cur.p;
      v      = operand;
      wd     = 8'h00;
      br     = 1'b0;
      t      = 8'h00;
      sum9   = 9'h000;
      borrow = 1'b0;
      src    = acc_target ? regs_cur.a : operand;

      case (mode)
         c6502_pkg::OP_ADC, c6502_pkg::OP_RRA: begin
            if (mode == c6502_pkg::OP_RRA) begin
               wd = {p[c6502_pkg::FLAG_C], operand[7:1]};
               p[c6502_pkg::FLAG_C] = operand[0];
               v = wd;
            end
            sum9 = {1'b0, a} + {1'b0, v} + {8'h00, p[c6502_pkg::FLAG_C]};
            p[c6502_pkg::FLAG_V] = ~(a[7] ^ v[7]) & (a[7] ^ sum9[7]);
            p[c6502_pkg::FLAG_C] = sum9[8];
            a = sum9[7:0];
            p = set_nz(p, a);
         end
         c6502_pkg::OP_SBC, c6502_pkg::OP_ISC: begin
            if (mode == c6502_pkg::OP_ISC) begin
               wd = operand + 8'h01;
               v = wd;
            end
            borrow = ~p[c6502_pkg::FLAG_C];
            sum9 = {1'b0, a} - {1'b0, v} - {8'h00, borrow};
            p[c6502_pkg::FLAG_V] = (a[7] ^ sum9[7]) & (a[7] ^ v[7]);
            p[c6502_pkg::FLAG_C] = ~sum9[8];
            a = sum9[7:0];
            p = set_nz(p, a);
         end
         c6502_pkg::OP_AND: begin a = a & v; p = set_nz(p, a); end
         c6502_pkg::OP_EOR: begin a = a ^ v; p = set_nz(p, a); end
         c6502_pkg::OP_ORA: begin a = a | v; p = set_nz(p, a); end
         c6502_pkg::OP_ASL: begin
            p[c6502_pkg::FLAG_C] = src[7];
            wd = {src[6:0], 1'b0};
            p = set_nz(p, wd);
         end
         c6502_pkg::OP_LSR: begin
            p[c6502_pkg::FLAG_C] = src[0];
            wd = {1'b0, src[7:1]};
            p = set_nz(p, wd);
         end
         c6502_pkg::OP_ROL: begin
            wd = {src[6:0], p[c6502_pkg::FLAG_C]};
            p[c6502_pkg::FLAG_C] = src[7];
            p = set_nz(p, wd);
         end
         c6502_pkg::OP_ROR: begin
            wd = {p[c6502_pkg::FLAG_C], src[7:1]};
            p[c6502_pkg::FLAG_C] = src[0];
            p = set_nz(p, wd);
         end
         c6502_pkg::OP_INC: begin wd = src + 8'h01; p = set_nz(p, wd); end
         c6502_pkg::OP_DEC: begin wd = src - 8'h01; p = set_nz(p, wd); end
         c6502_pkg::OP_BCC: br = ~p[c6502_pkg::FLAG_C];
         c6502_pkg::OP_BCS: br = p[c6502_pkg::FLAG_C];
         c6502_pkg::OP_BEQ: br = p[c6502_pkg::FLAG_Z];
         c6502_pkg::OP_BNE: br = ~p[c6502_pkg::FLAG_Z];
         c6502_pkg::OP_BMI: br = p[c6502_pkg::FLAG_N];
         c6502_pkg::OP_BPL: br = ~p[c6502_pkg::FLAG_N];
         c6502_pkg::OP_BVS: br = p[c6502_pkg::FLAG_V];
         c6502_pkg::OP_BVC: br = ~p[c6502_pkg::FLAG_V];
         c6502_pkg::OP_BIT: begin
            p[c6502_pkg::FLAG_N] = v[7];
            p[c6502_pkg::FLAG_V] = v[6];
            p[c6502_pkg::FLAG_Z] = ((a & v) == 8'h00);
         end
         c6502_pkg::OP_CLC: p[c6502_pkg::FLAG_C] = 1'b0;
         c6502_pkg::OP_CLD: p[c6502_pkg::FLAG_D] = 1'b0;
         c6502_pkg::OP_CLI: p[c6502_pkg::FLAG_I] = 1'b0;
         c6502_pkg::OP_CLV: p[c6502_pkg::FLAG_V] = 1'b0;
         c6502_pkg::OP_SEC: p[c6502_pkg::FLAG_C] = 1'b1;
         c6502_pkg::OP_SED: p[c6502_pkg::FLAG_D] = 1'b1;
         c6502_pkg::OP_SEI: p[c6502_pkg::FLAG_I] = 1'b1;
         c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY,
         c6502_pkg::OP_DCP: begin
            t = (mode == c6502_pkg::OP_CPX) ? x :
                (mode == c6502_pkg::OP_CPY) ? y : a;
            if (mode == c6502_pkg::OP_DCP) begin
               wd = operand - 8'h01;
               v = wd;
            end
            sum9 = {1'b0, t} - {1'b0, v};
            p[c6502_pkg::FLAG_C] = ~sum9[8];
            p = set_nz(p, sum9[7:0]);
         end
         c6502_pkg::OP_DEX: begin x = x - 8'h01; p = set_nz(p, x); end
         c6502_pkg::OP_DEY: begin y = y - 8'h01; p = set_nz(p, y); end
         c6502_pkg::OP_INX: begin x = x + 8'h01; p = set_nz(p, x); end
         c6502_pkg::OP_INY: begin y = y + 8'h01; p = set_nz(p, y); end
         c6502_pkg::OP_LDA: begin a = v; p = set_nz(p, v); end
         c6502_pkg::OP_LDX: begin x = v; p = set_nz(p, v); end
         c6502_pkg::OP_LDY: begin y = v; p = set_nz(p, v); end
         c6502_pkg::OP_NOP: ;
         c6502_pkg::OP_STA: wd = a;
         c6502_pkg::OP_STX: wd = x;
         c6502_pkg::OP_STY: wd = y;
         c6502_pkg::OP_TAX: begin x = a; p = set_nz(p, x); end
         c6502_pkg::OP_TAY: begin y = a; p = set_nz(p, y); end
         c6502_pkg::OP_TSX: begin x = sp; p = set_nz(p, x); end
         c6502_pkg::OP_TXA: begin a = x; p = set_nz(p, a); end
         c6502_pkg::OP_TXS: sp = x;
         c6502_pkg::OP_TYA: begin a = y; p = set_nz(p, a); end
         c6502_pkg::OP_ANC: begin
            a = a & v;
            p = set_nz(p, a);
            p[c6502_pkg::FLAG_C] = a[7];
         end
         c6502_pkg::OP_SAX: wd = a & x;
         c6502_pkg::OP_ARR: begin
            t = a & v;
            a = {p[c6502_pkg::FLAG_C], t[7:1]};
            p[c6502_pkg::FLAG_C] = a[6];
            p[c6502_pkg::FLAG_V] = a[6] ^ a[5];
            p = set_nz(p, a);
         end
         c6502_pkg::OP_ALR: begin
            t = a & v;
            p[c6502_pkg::FLAG_C] = t[0];
            a = {1'b0, t[7:1]};
            p = set_nz(p, a);
         end
         c6502_pkg::OP_AXA: wd = a & x & 8'h07;
         c6502_pkg::OP_AXS: begin
            t = a & x;
            sum9 = {1'b0, t} - {1'b0, v};
            p[c6502_pkg::FLAG_C] = ~sum9[8];
            x = sum9[7:0];
            p = set_nz(p, x);
         end
         c6502_pkg::OP_LAR: begin
            a = v & sp;
            x = a;
            sp = a;
            p = set_nz(p, a);
         end
         c6502_pkg::OP_LAX: begin a = v; x = v; p = set_nz(p, v); end
         c6502_pkg::OP_RLA: begin
            wd = {operand[6:0], p[c6502_pkg::FLAG_C]};
            p[c6502_pkg::FLAG_C] = operand[7];
            a = a & wd;
            p = set_nz(p, a);
         end
         c6502_pkg::OP_SLO: begin
            p[c6502_pkg::FLAG_C] = v[7];
            wd = {v[6:0], 1'b0};
            a = a | wd;
            p = set_nz(p, a);
         end
         c6502_pkg::OP_SRE: begin
            p[c6502_pkg::FLAG_C] = v[0];
            wd = {1'b0, v[7:1]};
            a = a ^ wd;
            p = set_nz(p, a);
         end
         c6502_pkg::OP_SXA: begin
            // page crossing leaves the operand byte unchanged
            t = eff_address[7:0] - y;
            sum9 = {1'b0, y} + {1'b0, t};
            wd = sum9[8] ? v : (x & (eff_address[15:8] + 8'h01));
         end
         c6502_pkg::OP_SYA: begin
            t = eff_address[7:0] - x;
            sum9 = {1'b0, x} + {1'b0, t};
            wd = sum9[8] ? v : (y & (eff_address[15:8] + 8'h01));
         end
         c6502_pkg::OP_XAA: begin a = x & v; p = set_nz(p, a); end
         default: ;
      endcase

      // read-modify-write on the accumulator
      if (acc_target && (mode == c6502_pkg::OP_ASL || mode == c6502_pkg::OP_LSR ||
                         mode == c6502_pkg::OP_ROL || mode == c6502_pkg::OP_ROR ||
                         mode == c6502_pkg::OP_INC || mode == c6502_pkg::OP_DEC)) begin
         a = wd;
      end

      regs_next.a  = a;
      regs_next.x  = x;
      regs_next.y  = y;
      regs_next.sp = sp;
      regs_next.p  = p;
      write_data   = wd;
      branch_taken = br;
   end

endmodule

FILE: hdl/cpu6502_execute_unit.sv
// ============================================================================
// cpu6502_execute_unit
// Execute stage of a 6502-style core (binary arithmetic only).
// ============================================================================
// usage:
//  - req channel: one transaction per instruction, carrying the operation
//    selector, operand byte, effective address and accumulator-target bit
//  - rsp channel: one transaction per instruction with the write-back byte,
//    branch decision and A, X, Y, SP and status after the instruction
//  - flow: a transaction is taken into the input register, executed from it
//    and presented on rsp from the result register (two register stages)
//  - throughput: one instruction per cycle while rsp is not stalled; the
//    register file is updated in the same cycle that the result register
//    loads, so the next instruction sees it with no bubble
//  - reset: A, X, Y cleared, SP = 0xFD, status = 0x24, both stages empty
//  - rsp_stall holds the result register; the input register then holds
//    too, and req_stall rises once the input register is full
// ============================================================================
module cpu6502_execute_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_mode,
   input  logic [7:0]  req_operand,
   input  logic [15:0] req_eff_address,
   input  logic        req_acc_target,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_branch_taken,
   output logic [7:0]  rsp_reg_a,
   output logic [7:0]  rsp_reg_x,
   output logic [7:0]  rsp_reg_y,
   output logic [7:0]  rsp_reg_sp,
   output logic [7:0]  rsp_status
);

   // input stage
   logic                in_valid_ff, in_valid_in;
   c6502_pkg::op_type   in_mode_ff;
   logic [7:0]          in_operand_ff;
   logic [15:0]         in_addr_ff;
   logic                in_acc_ff;

   // architectural registers
   c6502_pkg::arch_regs_type arch_ff, arch_in;

   // result stage
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_wd_ff;
   logic                out_br_ff;
   c6502_pkg::arch_regs_type out_regs_ff;

   logic                advance;     // result register can take a new value
   logic                execute;     // instruction retires this cycle
   logic                req_take;
   logic [7:0]          alu_wd;
   logic                alu_br;

   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign execute   = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   c6502_alu u_alu (
      .mode         (in_mode_ff),
      .operand      (in_operand_ff),
      .eff_address  (in_addr_ff),
      .acc_target   (in_acc_ff),
      .regs_cur     (arch_ff),
      .regs_next    (arch_in),
      .write_data   (alu_wd),
      .branch_taken (alu_br)
   );

   // input register refills whenever it is not held
   always_comb begin
      in_valid_in = in_valid_ff;
      if (~req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   // control state and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         arch_ff.a    <= c6502_pkg::A_RESET;
         arch_ff.x    <= c6502_pkg::X_RESET;
         arch_ff.y    <= c6502_pkg::Y_RESET;
         arch_ff.sp   <= c6502_pkg::SP_RESET;
         arch_ff.p    <= c6502_pkg::P_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (execute) begin
            arch_ff <= arch_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff    <= c6502_pkg::op_type'(req_mode);
         in_operand_ff <= req_operand;
         in_addr_ff    <= req_eff_address;
         in_acc_ff     <= req_acc_target;
      end
      if (execute) begin
         out_wd_ff   <= alu_wd;
         out_br_ff   <= alu_br;
         out_regs_ff <= arch_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_data   = out_wd_ff;
   assign rsp_branch_taken = out_br_ff;
   assign rsp_reg_a        = out_regs_ff.a;
   assign rsp_reg_x        = out_regs_ff.x;
   assign rsp_reg_y        = out_regs_ff.y;
   assign rsp_reg_sp       = out_regs_ff.sp;
   assign rsp_status       = out_regs_ff.p;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // the unused status bit always reads as one
   a_status_bit5: assert property (@(posedge clock) disable iff (reset)
      arch_ff.p[c6502_pkg::FLAG_U])
      else $error("status bit 5 cleared");

   // no instruction retires while the result is held
   a_hold_regs: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> $stable(arch_ff))
      else $error("register file changed while response stalled");

   // input side is only held back when both stages are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with a free stage");

   // a taken branch never carries a store byte
   a_branch_no_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_taken |-> rsp_write_data == 8'h00)
      else $error("taken branch with nonzero write data");

endmodule

FILE: tb/cpu6502_execute_unit_tb.sv
// ============================================================================
// cpu6502_execute_unit_tb
// Self-checking testbench for the 6502-style execute unit. A queue of
// instructions feeds a clocked driver. Each accepted transaction is run
// through an in-bench model of A, X, Y, SP and the status byte. A clocked
// monitor checks every response field against the oldest prediction. The
// run goes through three idle/stall mixes on the two channels.
// ============================================================================
`timescale 1ns / 1ps

module cpu6502_execute_unit_tb;

   // one instruction as it travels on the req channel
   typedef struct packed {
      c6502_pkg::op_type mode;
      logic [7:0]        operand;
      logic [15:0]       eff_address;
      logic              acc_target;
   } instr_type;

   // what the unit should return when it retires one instruction
   typedef struct packed {
      logic [7:0]               write_data;
      logic                     branch_taken;
      c6502_pkg::arch_regs_type regs;
   } retire_type;

   localparam int unsigned RANDOM_PER_PHASE = 235;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [5:0]  req_mode = 6'd0;
   logic [7:0]  req_operand = 8'd0;
   logic [15:0] req_eff_address = 16'd0;
   logic        req_acc_target = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_write_data;
   logic        rsp_branch_taken;
   logic [7:0]  rsp_reg_a;
   logic [7:0]  rsp_reg_x;
   logic [7:0]  rsp_reg_y;
   logic [7:0]  rsp_reg_sp;
   logic [7:0]  rsp_status;

   instr_type   pending_instrs[$];
   retire_type  predicted_retires[$];
   instr_type   next_instr;
   retire_type  retired_want;

   // architectural state as the model sees it
   c6502_pkg::arch_regs_type cpu_regs = '{a: c6502_pkg::A_RESET, x: c6502_pkg::X_RESET,
                                          y: c6502_pkg::Y_RESET, sp: c6502_pkg::SP_RESET,
                                          p: c6502_pkg::P_RESET};

   int unsigned send_idle_pct  = 20;
   int unsigned recv_stall_pct = 71;
   int unsigned mismatch_count = 0;
   int unsigned retire_count   = 0;

   cpu6502_execute_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_operand      (req_operand),
      .req_eff_address  (req_eff_address),
      .req_acc_target   (req_acc_target),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_data   (rsp_write_data),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_reg_a        (rsp_reg_a),
      .rsp_reg_x        (rsp_reg_x),
      .rsp_reg_y        (rsp_reg_y),
      .rsp_reg_sp       (rsp_reg_sp),
      .rsp_status       (rsp_status)
   );

   // ---------------------------------------------------------------------
   // clock and reset
   // ---------------------------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   // synchronous reset, asserted from the start and never raised again
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // hard stop in case the unit hangs a handshake
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // instruction model
   // ---------------------------------------------------------------------

   // N and Z follow the byte just produced
   function automatic void set_nz(input logic [7:0] v);
      cpu_regs.p[c6502_pkg::FLAG_N] = v[7];
      cpu_regs.p[c6502_pkg::FLAG_Z] = (v == 8'h00);
   endfunction

   // binary add with carry into A
   function automatic void add_to_acc(input logic [7:0] v);
      logic [8:0] sum;
      sum = {1'b0, cpu_regs.a} + {1'b0, v} + {8'd0, cpu_regs.p[c6502_pkg::FLAG_C]};
      cpu_regs.p[c6502_pkg::FLAG_V] = ~(cpu_regs.a[7] ^ v[7]) & (cpu_regs.a[7] ^ sum[7]);
      cpu_regs.p[c6502_pkg::FLAG_C] = sum[8];
      cpu_regs.a = sum[7:0];
      set_nz(cpu_regs.a);
   endfunction

   // binary subtract with borrow from A; carry is the inverted borrow
   function automatic void sub_from_acc(input logic [7:0] v);
      logic [8:0] diff;
      diff = {1'b0, cpu_regs.a} - {1'b0, v} - {8'd0, ~cpu_regs.p[c6502_pkg::FLAG_C]};
      cpu_regs.p[c6502_pkg::FLAG_V] = (cpu_regs.a[7] ^ diff[7]) & (cpu_regs.a[7] ^ v[7]);
      cpu_regs.p[c6502_pkg::FLAG_C] = ~diff[8];
      cpu_regs.a = diff[7:0];
      set_nz(cpu_regs.a);
   endfunction

   function automatic void compare_reg(input logic [7:0] r, input logic [7:0] v);
      cpu_regs.p[c6502_pkg::FLAG_C] = (r >= v);
      set_nz(r - v);
   endfunction

   function automatic logic [7:0] rotate_left(input logic [7:0] v);
      logic [7:0] r;
      r = {v[6:0], cpu_regs.p[c6502_pkg::FLAG_C]};
      cpu_regs.p[c6502_pkg::FLAG_C] = v[7];
      return r;
   endfunction

   function automatic logic [7:0] rotate_right(input logic [7:0] v);
      logic [7:0] r;
      r = {cpu_regs.p[c6502_pkg::FLAG_C], v[7:1]};
      cpu_regs.p[c6502_pkg::FLAG_C] = v[0];
      return r;
   endfunction

   // the unstable high-byte stores: data register AND (high byte + 1), unless
   // adding the index back to the low byte of the base carries into the high byte
   function automatic logic [7:0] unstable_store(input logic [7:0] base_idx,
                                                 input logic [7:0] data_reg,
                                                 input logic [15:0] addr,
                                                 input logic [7:0] v);
      logic [7:0] lo;
      lo = addr[7:0] - base_idx;
      if ({1'b0, base_idx} + {1'b0, lo} <= 9'h0FF) begin
         return data_reg & (addr[15:8] + 8'd1);
      end
      return v;
   endfunction

   // retire one instruction: update the model state, return the response
   function automatic retire_type retire_instr(input instr_type ins);
      retire_type r;
      logic [7:0] v, src, wd, t;
      logic       br;
      v   = ins.operand;
      src = ins.acc_target ? cpu_regs.a : v;
      wd  = 8'h00;
      br  = 1'b0;
      case (ins.mode)
         c6502_pkg::OP_ADC: add_to_acc(v);
         c6502_pkg::OP_AND: begin cpu_regs.a &= v; set_nz(cpu_regs.a); end
         c6502_pkg::OP_ASL: begin
            cpu_regs.p[c6502_pkg::FLAG_C] = src[7];
            wd = {src[6:0], 1'b0};
            set_nz(wd);
         end
         c6502_pkg::OP_LSR: begin
            cpu_regs.p[c6502_pkg::FLAG_C] = src[0];
            wd = {1'b0, src[7:1]};
            set_nz(wd);
         end
         c6502_pkg::OP_ROL: begin wd = rotate_left(src); set_nz(wd); end
         c6502_pkg::OP_ROR: begin wd = rotate_right(src); set_nz(wd); end
         c6502_pkg::OP_INC: begin wd = src + 8'd1; set_nz(wd); end
         c6502_pkg::OP_DEC: begin wd = src - 8'd1; set_nz(wd); end
         c6502_pkg::OP_BCC: br = ~cpu_regs.p[c6502_pkg::FLAG_C];
         c6502_pkg::OP_BCS: br = cpu_regs.p[c6502_pkg::FLAG_C];
         c6502_pkg::OP_BEQ: br = cpu_regs.p[c6502_pkg::FLAG_Z];
         c6502_pkg::OP_BNE: br = ~cpu_regs.p[c6502_pkg::FLAG_Z];
         c6502_pkg::OP_BMI: br = cpu_regs.p[c6502_pkg::FLAG_N];
         c6502_pkg::OP_BPL: br = ~cpu_regs.p[c6502_pkg::FLAG_N];
         c6502_pkg::OP_BVS: br = cpu_regs.p[c6502_pkg::FLAG_V];
         c6502_pkg::OP_BVC: br = ~cpu_regs.p[c6502_pkg::FLAG_V];
         c6502_pkg::OP_BIT: begin
            cpu_regs.p[c6502_pkg::FLAG_N] = v[7];
            cpu_regs.p[c6502_pkg::FLAG_V] = v[6];
            cpu_regs.p[c6502_pkg::FLAG_Z] = ((cpu_regs.a & v) == 8'h00);
         end
         c6502_pkg::OP_CLC: cpu_regs.p[c6502_pkg::FLAG_C] = 1'b0;
         c6502_pkg::OP_CLD: cpu_regs.p[c6502_pkg::FLAG_D] = 1'b0;
         c6502_pkg::OP_CLI: cpu_regs.p[c6502_pkg::FLAG_I] = 1'b0;
         c6502_pkg::OP_CLV: cpu_regs.p[c6502_pkg::FLAG_V] = 1'b0;
         c6502_pkg::OP_SEC: cpu_regs.p[c6502_pkg::FLAG_C] = 1'b1;
         c6502_pkg::OP_SED: cpu_regs.p[c6502_pkg::FLAG_D] = 1'b1;
         c6502_pkg::OP_SEI: cpu_regs.p[c6502_pkg::FLAG_I] = 1'b1;
         c6502_pkg::OP_CMP: compare_reg(cpu_regs.a, v);
         c6502_pkg::OP_CPX: compare_reg(cpu_regs.x, v);
         c6502_pkg::OP_CPY: compare_reg(cpu_regs.y, v);
         c6502_pkg::OP_DEX: begin cpu_regs.x -= 8'd1; set_nz(cpu_regs.x); end
         c6502_pkg::OP_DEY: begin cpu_regs.y -= 8'd1; set_nz(cpu_regs.y); end
         c6502_pkg::OP_INX: begin cpu_regs.x += 8'd1; set_nz(cpu_regs.x); end
         c6502_pkg::OP_INY: begin cpu_regs.y += 8'd1; set_nz(cpu_regs.y); end
         c6502_pkg::OP_EOR: begin cpu_regs.a ^= v; set_nz(cpu_regs.a); end
         c6502_pkg::OP_ORA: begin cpu_regs.a |= v; set_nz(cpu_regs.a); end
         c6502_pkg::OP_LDA: begin cpu_regs.a = v; set_nz(v); end
         c6502_pkg::OP_LDX: begin cpu_regs.x = v; set_nz(v); end
         c6502_pkg::OP_LDY: begin cpu_regs.y = v; set_nz(v); end
         c6502_pkg::OP_NOP: ;
         c6502_pkg::OP_SBC: sub_from_acc(v);
         c6502_pkg::OP_STA: wd = cpu_regs.a;
         c6502_pkg::OP_STX: wd = cpu_regs.x;
         c6502_pkg::OP_STY: wd = cpu_regs.y;
         c6502_pkg::OP_TAX: begin cpu_regs.x = cpu_regs.a; set_nz(cpu_regs.x); end
         c6502_pkg::OP_TAY: begin cpu_regs.y = cpu_regs.a; set_nz(cpu_regs.y); end
         c6502_pkg::OP_TSX: begin cpu_regs.x = cpu_regs.sp; set_nz(cpu_regs.x); end
         c6502_pkg::OP_TXA: begin cpu_regs.a = cpu_regs.x; set_nz(cpu_regs.a); end
         c6502_pkg::OP_TXS: cpu_regs.sp = cpu_regs.x;
         c6502_pkg::OP_TYA: begin cpu_regs.a = cpu_regs.y; set_nz(cpu_regs.a); end
         c6502_pkg::OP_ANC: begin
            cpu_regs.a &= v;
            set_nz(cpu_regs.a);
            cpu_regs.p[c6502_pkg::FLAG_C] = cpu_regs.a[7];
         end
         c6502_pkg::OP_SAX: wd = cpu_regs.a & cpu_regs.x;
         c6502_pkg::OP_ARR: begin
            cpu_regs.a = rotate_right(cpu_regs.a & v);
            cpu_regs.p[c6502_pkg::FLAG_C] = cpu_regs.a[6];
            cpu_regs.p[c6502_pkg::FLAG_V] = cpu_regs.a[6] ^ cpu_regs.a[5];
            set_nz(cpu_regs.a);
         end
         c6502_pkg::OP_ALR: begin
            t = cpu_regs.a & v;
            cpu_regs.p[c6502_pkg::FLAG_C] = t[0];
            cpu_regs.a = {1'b0, t[7:1]};
            set_nz(cpu_regs.a);
         end
         // quirky form: only the low three bits survive
         c6502_pkg::OP_AXA: wd = cpu_regs.a & cpu_regs.x & 8'h07;
         c6502_pkg::OP_AXS: begin
            t = cpu_regs.a & cpu_regs.x;
            cpu_regs.p[c6502_pkg::FLAG_C] = (t >= v);
            cpu_regs.x = t - v;
            set_nz(cpu_regs.x);
         end
         c6502_pkg::OP_DCP: begin wd = v - 8'd1; compare_reg(cpu_regs.a, wd); end
         c6502_pkg::OP_ISC: begin wd = v + 8'd1; sub_from_acc(wd); end
         c6502_pkg::OP_LAR: begin
            cpu_regs.a  = v & cpu_regs.sp;
            cpu_regs.x  = cpu_regs.a;
            cpu_regs.sp = cpu_regs.a;
            set_nz(cpu_regs.a);
         end
         c6502_pkg::OP_LAX: begin cpu_regs.a = v; cpu_regs.x = v; set_nz(v); end
         c6502_pkg::OP_RLA: begin
            wd = rotate_left(v);
            cpu_regs.a &= wd;
            set_nz(cpu_regs.a);
         end
         c6502_pkg::OP_RRA: begin wd = rotate_right(v); add_to_acc(wd); end
         c6502_pkg::OP_SLO: begin
            cpu_regs.p[c6502_pkg::FLAG_C] = v[7];
            wd = {v[6:0], 1'b0};
            cpu_regs.a |= wd;
            set_nz(cpu_regs.a);
         end
         c6502_pkg::OP_SRE: begin
            cpu_regs.p[c6502_pkg::FLAG_C] = v[0];
            wd = {1'b0, v[7:1]};
            cpu_regs.a ^= wd;
            set_nz(cpu_regs.a);
         end
         c6502_pkg::OP_SXA:
            wd = unstable_store(cpu_regs.y, cpu_regs.x, ins.eff_address, v);
         c6502_pkg::OP_SYA:
            wd = unstable_store(cpu_regs.x, cpu_regs.y, ins.eff_address, v);
         c6502_pkg::OP_XAA: begin cpu_regs.a = cpu_regs.x & v; set_nz(cpu_regs.a); end
         default: ;
      endcase
      // read-modify-write ops aimed at the accumulator
      if (ins.acc_target && (ins.mode inside {c6502_pkg::OP_ASL, c6502_pkg::OP_LSR,
                                              c6502_pkg::OP_ROL, c6502_pkg::OP_ROR,
                                              c6502_pkg::OP_INC, c6502_pkg::OP_DEC})) begin
         cpu_regs.a = wd;
      end
      r.write_data   = wd;
      r.branch_taken = br;
      r.regs         = cpu_regs;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // reporting
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t rsp #%0d: %s", $realtime, retire_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: presents queued instructions, predicts on each accepted one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // the transaction on the bus was taken at this edge
         if (req_valid) begin
            predicted_retires.push_back(retire_instr(instr_type'{
               mode: c6502_pkg::op_type'(req_mode), operand: req_operand,
               eff_address: req_eff_address, acc_target: req_acc_target}));
         end
         if (pending_instrs.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            next_instr = pending_instrs.pop_front();
            req_mode        <= next_instr.mode;
            req_operand     <= next_instr.operand;
            req_eff_address <= next_instr.eff_address;
            req_acc_target  <= next_instr.acc_target;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: random back-pressure, compares every accepted response
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_retires.size() == 0) begin
               report_mismatch("response with no instruction outstanding");
            end else begin
               retired_want = predicted_retires.pop_front();
               check_field("write_data", rsp_write_data, retired_want.write_data);
               check_field("branch_taken", {7'd0, rsp_branch_taken},
                           {7'd0, retired_want.branch_taken});
               check_field("reg_a", rsp_reg_a, retired_want.regs.a);
               check_field("reg_x", rsp_reg_x, retired_want.regs.x);
               check_field("reg_y", rsp_reg_y, retired_want.regs.y);
               check_field("reg_sp", rsp_reg_sp, retired_want.regs.sp);
               check_field("status", rsp_status, retired_want.regs.p);
            end
            retire_count++;
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic queue_instr(input c6502_pkg::op_type op, input logic [7:0] operand,
                              input logic [15:0] addr, input logic acc);
      pending_instrs.push_back(instr_type'{mode: op, operand: operand,
                                           eff_address: addr, acc_target: acc});
   endtask

   // every queued transaction sent and every response back
   task automatic wait_drained();
      while (pending_instrs.size() != 0 || req_valid ||
             predicted_retires.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      instr_type ins;
      while (reset) @(posedge clock);

      // directed: unstable stores on both sides of the page carry
      queue_instr(c6502_pkg::OP_LDX, 8'h10, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_LDY, 8'hF0, 16'hFFFF, 1'b0);
      queue_instr(c6502_pkg::OP_SXA, 8'h5A, 16'h12F5, 1'b0);   // no carry: X & 0x13
      queue_instr(c6502_pkg::OP_SXA, 8'hA5, 16'h1205, 1'b0);   // carry: operand stored
      queue_instr(c6502_pkg::OP_SYA, 8'hC3, 16'hFFFF, 1'b0);   // high byte + 1 wraps
      queue_instr(c6502_pkg::OP_SYA, 8'h3C, 16'h0000, 1'b0);
      // quirky AXA mask, and LAX with zero and negative operands
      queue_instr(c6502_pkg::OP_LDA, 8'hFF, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_AXA, 8'h00, 16'hFFFF, 1'b0);
      queue_instr(c6502_pkg::OP_LAX, 8'h00, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_LAX, 8'h80, 16'h0000, 1'b0);
      // signed overflow on add, borrow on subtract
      queue_instr(c6502_pkg::OP_LDA, 8'h7F, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_CLC, 8'h00, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_ADC, 8'h01, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_SEC, 8'h00, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_SBC, 8'hFF, 16'h0000, 1'b0);
      // read-modify-write, accumulator and memory targets
      queue_instr(c6502_pkg::OP_ASL, 8'h81, 16'h0000, 1'b1);
      queue_instr(c6502_pkg::OP_ROR, 8'h01, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_INC, 8'hFF, 16'h0000, 1'b1);
      queue_instr(c6502_pkg::OP_DEC, 8'h00, 16'h0000, 1'b0);
      // decimal flag has no effect on arithmetic
      queue_instr(c6502_pkg::OP_SED, 8'h00, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_ADC, 8'h09, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_CLD, 8'h00, 16'h0000, 1'b0);
      // branch taken and not taken, stack pointer moves, plain store
      queue_instr(c6502_pkg::OP_BEQ, 8'h00, 16'hFFFF, 1'b0);
      queue_instr(c6502_pkg::OP_BNE, 8'hFF, 16'h8000, 1'b1);
      queue_instr(c6502_pkg::OP_TXS, 8'h00, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_TSX, 8'h00, 16'h0000, 1'b0);
      queue_instr(c6502_pkg::OP_STA, 8'hFF, 16'hFFFF, 1'b1);

      // three idle mixes: sender-light, receiver-light, back to back
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 20; recv_stall_pct = 71; end
            1: begin send_idle_pct = 71; recv_stall_pct = 20; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            ins.mode = c6502_pkg::op_type'(6'($urandom_range(0, 63)));
            // extremes show up often enough to hit carries and zero results
            case ($urandom_range(0, 7))
               0: ins.operand = 8'h00;
               1: ins.operand = 8'hFF;
               2: ins.operand = 8'h80;
               3: ins.operand = 8'h7F;
               default: ins.operand = 8'($urandom_range(0, 255));
            endcase
            ins.eff_address = 16'($urandom_range(0, 65535));
            ins.acc_target  = 1'($urandom_range(0, 1));
            pending_instrs.push_back(ins);
         end
         wait_drained();
      end

      // let any stray response show up before the verdict
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && predicted_retires.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/c6502_pkg.sv
hdl/c6502_alu.sv
hdl/cpu6502_execute_unit.sv
tb/cpu6502_execute_unit_tb.sv
